/* rtl/core/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked on every rising clock edge while out of reset
`define MLBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising clock edge, reset included
`define MLBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define MLBD_ASSERT(lbl, prop, msg)
`define MLBD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/core/mlbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlbd_pkg
// Types and constants of the magic-word, length-prefixed block deframer.
// ----------------------------------------------------------------------------
package mlbd_pkg;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic CFG_IDX_MAGIC   = 1'b0;
  localparam logic CFG_IDX_MIN_LEN = 1'b1;

  localparam logic [31:0] MAGIC_RESET   = 32'hD9B4_BEF9;
  localparam logic [31:0] MIN_LEN_RESET = 32'd80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        first_of_block;
    logic        last_of_block;
    logic        block_abort;
    logic [31:0] block_length;
  } out_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [31:0] min_block_length;
  } cfg_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

  typedef enum logic [2:0] {
    MODE_HUNT    = 3'b001,
    MODE_LENGTH  = 3'b010,
    MODE_PAYLOAD = 3'b100
  } mode_e;

endpackage

/* rtl/core/magic_length_block_deframer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magic_length_block_deframer_top
// Byte-stream deframer: hunts for a sync word, reads a little-endian length
// and passes the block payload with first, last and abort marks.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i / in_stall_o / in_data_i): one raw byte per
//     transfer, end_of_file set on the last byte of each file.
//   out channel (out_valid_o / out_stall_i / out_data_o): one transfer per
//     payload byte; sync and length bytes give no output.
//   APB port: register 0 at address 0 is the sync word (first stream byte in
//     bits 7:0), register 1 at address 4 is the minimum block length.
//   Throughput: one byte per clock while the output is not stalled. Each byte
//     is held in the input register while the state update runs on it, and a
//     payload byte then passes to the output register that drives out_valid_o.
//   Stall: the output register holds its result while out_stall_i is high;
//     the input register holds one more byte, then in_stall_o rises.
//     Bytes that give no output keep flowing while the output waits.
//   Reset: asynchronous, active low; the APB registers return to their defaults,
//     the deframer hunts with an empty window, both channels are empty.
//   A file ending mid-block gives block_abort on its last byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module magic_length_block_deframer_top
  import mlbd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  res_t res;
  in_t  in_q;
  logic in_valid_q;
  out_t out_q;
  logic out_valid_q;
  logic slot_free;
  logic advance;
  logic in_xfer;

  mlbd_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mlbd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // output slot frees when empty or being taken this cycle
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!res.valid || slot_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MLBD_ASSERT(a_abort_not_last, out_valid_o |-> !(out_data_o.block_abort && out_data_o.last_of_block), "abort and last set together")
  `MLBD_ASSERT(a_no_overwrite, (out_valid_q && out_stall_i) |-> !(advance && res.valid), "result overwrites a stalled output")
  `MLBD_ASSERT_ALWAYS(a_stall_needs_item, in_stall_o |-> in_valid_q, "input stalled with empty input register")

endmodule

/* rtl/core/mlbd_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlbd_cfg_regs
// APB register file holding the sync word and the minimum block length.
// ----------------------------------------------------------------------------
module mlbd_cfg_regs
  import mlbd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [31:0] magic_q;
  logic [31:0] min_len_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= MAGIC_RESET;
      min_len_q <= MIN_LEN_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        CFG_IDX_MAGIC:   magic_q   <= pwdata;
        CFG_IDX_MIN_LEN: min_len_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_IDX_MAGIC:   prdata = magic_q;
      CFG_IDX_MIN_LEN: prdata = min_len_q;
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.magic_word       = magic_q;
  assign cfg_o.min_block_length = min_len_q;

endmodule

/* rtl/core/mlbd_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlbd_core
// Deframer state and the per-byte update: sync hunt, length field, payload.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlbd_core
  import mlbd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_en_i,
  input  in_t  item_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  mode_e       mode_q, mode_d;
  logic [23:0] win_q, win_d;
  logic [1:0]  fill_q, fill_d;
  logic [31:0] shift_q, shift_d;
  logic [1:0]  seen_q, seen_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] cur_q, cur_d;
  logic [31:0] len_new;
  logic        last;

  assign len_new = {item_i.data_byte, shift_q[31:8]};
  assign last    = (rem_q == 32'd1);

  always_comb begin
    mode_d  = mode_q;
    win_d   = win_q;
    fill_d  = fill_q;
    shift_d = shift_q;
    seen_d  = seen_q;
    rem_d   = rem_q;
    cur_d   = cur_q;
    res_o   = '0;

    unique case (mode_q)
      MODE_LENGTH: begin
        shift_d = len_new;
        if (item_i.end_of_file) begin
          mode_d  = MODE_HUNT;
          win_d   = '0;
          fill_d  = '0;
          shift_d = '0;
          seen_d  = '0;
        end else if (seen_q != 2'd3) begin
          seen_d = seen_q + 2'd1;
        end else begin
          mode_d  = MODE_HUNT;
          win_d   = '0;
          fill_d  = '0;
          shift_d = '0;
          seen_d  = '0;
          if ((len_new >= cfg_i.min_block_length) && (len_new != '0)) begin
            mode_d = MODE_PAYLOAD;
            rem_d  = len_new;
            cur_d  = len_new;
          end
        end
      end

      MODE_PAYLOAD: begin
        res_o.valid               = 1'b1;
        res_o.data.out_byte       = item_i.data_byte;
        res_o.data.first_of_block = (rem_q == cur_q);
        res_o.data.last_of_block  = last;
        res_o.data.block_abort    = item_i.end_of_file && !last;
        res_o.data.block_length   = cur_q;
        rem_d = rem_q - 32'd1;
        if (last || item_i.end_of_file) begin
          rem_d   = '0;
          mode_d  = MODE_HUNT;
          win_d   = '0;
          fill_d  = '0;
          shift_d = '0;
          seen_d  = '0;
        end
      end

      default: begin
        // window cleared at end of file, so sync never spans two files
        if (item_i.end_of_file) begin
          mode_d  = MODE_HUNT;
          win_d   = '0;
          fill_d  = '0;
          shift_d = '0;
          seen_d  = '0;
        end else if ((fill_q == 2'd3) &&
                     ({item_i.data_byte, win_q} == cfg_i.magic_word)) begin
          mode_d  = MODE_LENGTH;
          win_d   = '0;
          fill_d  = '0;
          shift_d = '0;
          seen_d  = '0;
        end else begin
          mode_d = MODE_HUNT;
          win_d  = {item_i.data_byte, win_q[23:8]};
          if (fill_q != 2'd3) begin
            fill_d = fill_q + 2'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_HUNT;
      win_q   <= '0;
      fill_q  <= '0;
      shift_q <= '0;
      seen_q  <= '0;
      rem_q   <= '0;
      cur_q   <= '0;
    end else if (step_en_i) begin
      mode_q  <= mode_d;
      win_q   <= win_d;
      fill_q  <= fill_d;
      shift_q <= shift_d;
      seen_q  <= seen_d;
      rem_q   <= rem_d;
      cur_q   <= cur_d;
    end
  end

  `MLBD_ASSERT(a_payload_has_bytes, (mode_q == MODE_PAYLOAD) |-> (rem_q != '0), "payload mode with no bytes left")
  `MLBD_ASSERT(a_idle_count_clear, (mode_q != MODE_PAYLOAD) |-> (rem_q == '0), "byte count left over outside payload")
  `MLBD_ASSERT(a_length_window_clear, (mode_q == MODE_LENGTH) |-> ((win_q == '0) && (fill_q == '0)), "sync window not cleared on length field")

endmodule

/* sim/magic_length_block_deframer_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magic_length_block_deframer_top_test
// Self-checking bench for the block deframer. It drives framed byte streams
// with random gaps and output stalls, predicts every payload transfer from
// its own model of the deframer and compares the results field by field.
// ----------------------------------------------------------------------------
import mlbd_pkg::*;

class deframe_scoreboard;
  logic [31:0] magic_word;
  logic [31:0] min_len;

  mode_e       mode;
  logic [23:0] window;
  logic [1:0]  fill;
  logic [31:0] len_shift;
  logic [1:0]  len_seen;
  logic [31:0] remaining;
  logic [31:0] cur_len;

  out_t        payload_q[$];
  int unsigned errors;

  function new();
    magic_word = MAGIC_RESET;
    min_len    = MIN_LEN_RESET;
    restart_hunt();
    remaining  = '0;
    cur_len    = '0;
    errors     = 0;
  endfunction

  function void restart_hunt();
    mode      = MODE_HUNT;
    window    = '0;
    fill      = '0;
    len_shift = '0;
    len_seen  = '0;
  endfunction

  function int unsigned pending();
    return payload_q.size();
  endfunction

  function void note_error(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 10) begin
      $display("mismatch %s: expected %h, got %h", what, want, got);
    end
  endfunction

  // update the deframer state for one accepted input transfer
  function void note_byte(in_t item);
    out_t        r;
    logic [31:0] len_val;
    logic        is_first;
    logic        is_last;
    case (mode)
      MODE_LENGTH: begin
        len_shift = {item.data_byte, len_shift[31:8]};
        if (item.end_of_file) begin
          restart_hunt();
        end else if (len_seen < 2'd3) begin
          len_seen++;
        end else begin
          len_val = len_shift;
          restart_hunt();
          if (len_val >= min_len && len_val != 0) begin
            mode      = MODE_PAYLOAD;
            remaining = len_val;
            cur_len   = len_val;
          end
        end
      end
      MODE_PAYLOAD: begin
        is_first         = (remaining == cur_len);
        is_last          = (remaining == 32'd1);
        r.out_byte       = item.data_byte;
        r.first_of_block = is_first;
        r.last_of_block  = is_last;
        r.block_abort    = item.end_of_file && !is_last;
        r.block_length   = cur_len;
        payload_q.push_back(r);
        remaining--;
        if (is_last || item.end_of_file) begin
          remaining = '0;
          restart_hunt();
        end
      end
      default: begin
        if (item.end_of_file) begin
          restart_hunt();
        end else if (fill == 2'd3 && {item.data_byte, window} == magic_word) begin
          restart_hunt();
          mode = MODE_LENGTH;
        end else begin
          mode   = MODE_HUNT;
          window = {item.data_byte, window[23:8]};
          if (fill < 2'd3) fill++;
        end
      end
    endcase
  endfunction

  function void check_result(out_t got);
    out_t want;
    if (payload_q.size() == 0) begin
      note_error("unexpected transfer, byte", '0, got.out_byte);
      return;
    end
    want = payload_q.pop_front();
    if (got.out_byte !== want.out_byte)
      note_error("out_byte", want.out_byte, got.out_byte);
    if (got.first_of_block !== want.first_of_block)
      note_error("first_of_block", want.first_of_block, got.first_of_block);
    if (got.last_of_block !== want.last_of_block)
      note_error("last_of_block", want.last_of_block, got.last_of_block);
    if (got.block_abort !== want.block_abort)
      note_error("block_abort", want.block_abort, got.block_abort);
    if (got.block_length !== want.block_length)
      note_error("block_length", want.block_length, got.block_length);
  endfunction
endclass

module magic_length_block_deframer_top_test;

  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE      = 10;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_t                  out_data_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  deframe_scoreboard model;
  int unsigned       sent_count   = 0;
  int unsigned       hold_request = 0;
  bit                no_idle      = 1'b0;

  magic_length_block_deframer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int unsigned idle_draw();
    if (no_idle) return 0;
    return $urandom_range(0, 15);
  endfunction

  task automatic put_byte(input logic [7:0] data, input logic eof);
    in_t         item;
    int unsigned gap;
    item.data_byte   = data;
    item.end_of_file = eof;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!(in_valid_i === 1'b1 && in_stall_o === 1'b0));
    model.note_byte(item);
    sent_count++;
  endtask

  // leading bytes of the current sync word, optionally ending the file
  task automatic put_sync(input int unsigned count, input logic eof_on_last);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      put_byte(model.magic_word[8*k +: 8], eof_on_last && (k == count - 1));
    end
  endtask

  task automatic send_frame();
    int unsigned n;
    int unsigned r;
    int unsigned k;
    int unsigned len_eof;
    int unsigned cut;
    logic [31:0] len;
    logic [31:0] minv;
    logic        eof_flag;
    minv = model.min_len;
    n = $urandom_range(0, 3);
    repeat (n) put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    r = $urandom_range(0, 99);
    if (r < 6) return;
    if (r < 18) begin
      // broken sync: cut by end of file or by a wrong byte
      cut      = $urandom_range(1, 3);
      eof_flag = 1'($urandom_range(0, 1));
      put_sync(cut, eof_flag);
      if (!eof_flag)
        put_byte(8'(model.magic_word[8*cut +: 8] ^ $urandom_range(1, 255)), 1'b0);
      return;
    end
    put_sync(4, 1'b0);
    r = $urandom_range(0, 99);
    if (r < 12) len = (minv == 0) ? 32'd0 : ($urandom % minv);
    else if (r < 17) len = $urandom;
    else if (minv > 32'hFFFF_FFF0) len = 32'hFFFF_FFFF;
    else len = minv + $urandom_range(0, 8);
    len_eof = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 3) : 4;
    for (k = 0; k < 4; k++) begin
      put_byte(len[8*k +: 8], k == len_eof);
      if (k == len_eof) return;
    end
    if (len < minv || len == 0) return;
    // long blocks are cut short by an end of file
    if (len > 96) begin
      cut = $urandom_range(1, 5);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) cut = 0;
      else if (r < 85) cut = len;
      else cut = $urandom_range(1, len);
    end
    n = (cut == 0) ? len : cut;
    for (k = 1; k <= n; k++) begin
      put_byte(8'($urandom_range(0, 255)), k == cut);
    end
  endtask

  task automatic run_frames(input int unsigned budget);
    int unsigned stop_at;
    stop_at = sent_count + budget;
    while (sent_count < stop_at) send_frame();
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (idx == CFG_IDX_MAGIC) model.magic_word = value;
    else model.min_len = value;
    // read it back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== value) model.note_error("register readback", value, prdata);
  endtask

  initial begin : receiver
    int unsigned n;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      n = idle_draw();
      if (hold_request != 0) begin
        n = hold_request;
        hold_request = 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i === 1'b0));
      model.check_result(out_data_o);
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("magic_length_block_deframer_top_test: errors");
    $finish;
  end

  initial begin : stimulus
    model       = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part with the default sync word
    write_reg(CFG_IDX_MIN_LEN, 32'd3);
    put_sync(4, 1'b1);                 // sync on the last byte of a file
    put_sync(4, 1'b0);                 // length below the minimum
    put_byte(8'h02, 1'b0);
    repeat (3) put_byte(8'h00, 1'b0);
    put_sync(4, 1'b0);                 // file ends inside the length field
    put_byte(8'h03, 1'b0);
    put_byte(8'h00, 1'b1);
    put_sync(4, 1'b0);                 // file ends mid-payload
    put_byte(8'h03, 1'b0);
    repeat (3) put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b1);
    wait_idle();

    write_reg(CFG_IDX_MAGIC, MAGIC_RESET);
    write_reg(CFG_IDX_MIN_LEN, MIN_LEN_RESET);
    run_frames(250);
    wait_idle();

    write_reg(CFG_IDX_MAGIC, 32'h0000_0000);
    write_reg(CFG_IDX_MIN_LEN, 32'd0);
    run_frames(250);
    wait_idle();

    write_reg(CFG_IDX_MAGIC, 32'hFFFF_FFFF);
    write_reg(CFG_IDX_MIN_LEN, 32'd1);
    run_frames(200);
    wait_idle();

    // long output hold-off so the input side backs up
    write_reg(CFG_IDX_MAGIC, $urandom);
    write_reg(CFG_IDX_MIN_LEN, $urandom_range(2, 20));
    hold_request = 400;
    run_frames(250);
    wait_idle();

    write_reg(CFG_IDX_MIN_LEN, 32'hFFFF_FFFF);
    run_frames(100);
    wait_idle();

    write_reg(CFG_IDX_MAGIC, $urandom);
    write_reg(CFG_IDX_MIN_LEN, $urandom_range(2, 12));
    no_idle = 1'b1;
    run_frames(150);
    no_idle = 1'b0;
    run_frames(250);
    wait_idle();

    if (model.errors == 0) begin
      $display("magic_length_block_deframer_top_test: clean");
    end else begin
      $display("magic_length_block_deframer_top_test: errors");
    end
    $finish;
  end

endmodule
